FILE: rtl/scv_pkg.sv
`timescale 1ns / 1ps

package scv_pkg;

    localparam int COORD_BITS  = 24;
    localparam int T_FRAC_BITS = 16;

    typedef enum logic [1:0] {
        TSEL_ZERO,
        TSEL_ONE,
        TSEL_DIV,
        TSEL_T0
    } t_tsel;

endpackage

FILE: rtl/segment_cylinder_hit_test.sv
`timescale 1ns / 1ps
// Throughput: one beat per cycle while i_out_stall is low; the three one-bit-per-stage
// divider pipelines set the depth.
// Reset: synchronous, active low; it clears all stage valid bits, and the pipeline
// is ready in the cycle after reset is released.
module segment_cylinder_hit_test #(
    parameter int COORD_BITS  = scv_pkg::COORD_BITS,
    parameter int T_FRAC_BITS = scv_pkg::T_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [COORD_BITS-1:0] i_seg_ax,
    input  logic signed [COORD_BITS-1:0] i_seg_ay,
    input  logic signed [COORD_BITS-1:0] i_seg_az,
    input  logic signed [COORD_BITS-1:0] i_seg_bx,
    input  logic signed [COORD_BITS-1:0] i_seg_by,
    input  logic signed [COORD_BITS-1:0] i_seg_bz,
    input  logic signed [COORD_BITS-1:0] i_cyl_x,
    input  logic signed [COORD_BITS-1:0] i_cyl_y,
    input  logic signed [COORD_BITS-1:0] i_cyl_z,
    input  logic signed [COORD_BITS-1:0] i_cyl_base_offset,
    input  logic        [COORD_BITS-2:0] i_cyl_height,
    input  logic        [COORD_BITS-2:0] i_cyl_radius,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_hit,
    output logic signed [COORD_BITS-1:0] o_contact_x,
    output logic signed [COORD_BITS-1:0] o_contact_y,
    output logic signed [COORD_BITS-1:0] o_contact_z
);

    localparam int CB  = COORD_BITS;
    localparam int TF  = T_FRAC_BITS;
    localparam int DW  = CB + 1;
    localparam int SW  = CB + 3;
    localparam int PW  = 2 * DW;
    localparam int NW  = 2 * DW;
    localparam int QW  = NW + 1;
    localparam int TB  = TF + 1;
    localparam int MW  = DW + TF + 2;
    localparam int RW  = 2 * (CB - 1);
    localparam int DL  = TF + 1;
    localparam int SBW = 1 + 6 + 3 * DW + 5 * CB + (CB - 1);
    localparam logic [TB-1:0] T_ONE = TB'(1) << TF;

    logic w_adv;

    // Stage 1
    logic                 r1_vld, r1_kill;
    logic signed [DW-1:0] r1_dx, r1_dy, r1_dz, r1_cxa, r1_cza;
    logic signed [SW-1:0] r1_low;
    logic signed [CB-1:0] r1_ax, r1_ay, r1_az, r1_cx, r1_cz;
    logic        [CB-2:0] r1_h, r1_r;

    // Stage 2
    logic                 r2_vld, r2_kill, r2_dy0, r2_in;
    logic signed [SW-1:0] r2_lon, r2_hin;
    logic        [DW-1:0] r2_d;
    logic signed [PW-1:0] r2_dxx, r2_dzz, r2_pxn, r2_pzn;
    logic signed [DW-1:0] r2_dx, r2_dy, r2_dz;
    logic signed [CB-1:0] r2_ax, r2_ay, r2_az, r2_cx, r2_cz;
    logic        [CB-2:0] r2_r;
    logic signed [SW-1:0] n2_high, n2_ay, n2_lon, n2_hin;
    logic        [DW-1:0] n2_d;
    logic                 n2_pos;

    // Stage 3
    logic                 r3_vld, r3_kill;
    scv_pkg::t_tsel       r3_m0, r3_m1, r3_mn;
    logic        [DW-1:0] r3_n0, r3_n1, r3_d;
    logic        [NW-1:0] r3_nn, r3_dn;
    logic signed [DW-1:0] r3_dx, r3_dy, r3_dz;
    logic signed [CB-1:0] r3_ax, r3_ay, r3_az, r3_cx, r3_cz;
    logic        [CB-2:0] r3_r;
    logic signed [QW-1:0] n3_den, n3_num;
    logic signed [SW-1:0] n3_d;
    logic                 n3_kill;
    scv_pkg::t_tsel       n3_m0, n3_m1, n3_mn;

    // Divider and sideband outputs
    logic        [TB-1:0] w_q0, w_q1, w_qn;
    logic [SBW-1:0]       w_sb_in, w_sb_out;
    logic [DL-1:0]        r_vdl;
    logic                 w_kill;
    logic [1:0]           w_m0b, w_m1b, w_mnb;
    logic signed [DW-1:0] w_dx, w_dy, w_dz;
    logic signed [CB-1:0] w_ax, w_ay, w_az, w_cx, w_cz;
    logic        [CB-2:0] w_r;
    logic        [TB-1:0] n4_t0, n4_t1, n4_tn, n4_tc, n4_t;

    // Stage 4
    logic                 r4_vld, r4_kill;
    logic        [TB-1:0] r4_t;
    logic signed [DW-1:0] r4_dx, r4_dy, r4_dz;
    logic signed [CB-1:0] r4_ax, r4_ay, r4_az, r4_cx, r4_cz;
    logic        [CB-2:0] r4_r;

    // Stage 5
    logic                 r5_vld, r5_kill;
    logic signed [MW-1:0] r5_mx, r5_my, r5_mz;
    logic signed [CB-1:0] r5_ax, r5_ay, r5_az, r5_cx, r5_cz;
    logic        [CB-2:0] r5_r;
    logic signed [TF+1:0] w5_t;

    // Stage 6
    logic                 r6_vld, r6_kill;
    logic signed [CB-1:0] r6_px, r6_py, r6_pz, r6_cx, r6_cz;
    logic        [CB-2:0] r6_r;
    logic signed [MW-1:0] n6_wx, n6_wy, n6_wz, n6_sx, n6_sy, n6_sz;

    // Stage 7
    logic                 r7_vld, r7_kill;
    logic signed [DW-1:0] r7_ex, r7_ez;
    logic signed [CB-1:0] r7_px, r7_py, r7_pz;
    logic        [CB-2:0] r7_r;

    // Stage 8
    logic                 r8_vld, r8_kill;
    logic signed [PW-1:0] r8_exx, r8_ezz;
    logic        [RW-1:0] r8_rr;
    logic signed [CB-1:0] r8_px, r8_py, r8_pz;

    // Stage 9 (output)
    logic                 r9_vld, r9_hit;
    logic signed [CB-1:0] r9_x, r9_y, r9_z;
    logic        [PW:0]   n9_dist;
    logic                 n9_hit;

    assign w_adv      = !r9_vld || !i_out_stall;
    assign o_in_stall = !w_adv;

    // Stage 2 combinational
    assign n2_pos  = !r1_dy[DW-1] && (r1_dy != '0);
    assign n2_high = r1_low + SW'({1'b0, r1_h});
    assign n2_ay   = SW'(r1_ay);
    assign n2_lon  = n2_pos ? (r1_low - n2_ay) : (n2_ay - n2_high);
    assign n2_hin  = n2_pos ? (n2_high - n2_ay) : (n2_ay - r1_low);
    assign n2_d    = r1_dy[DW-1] ? DW'(-r1_dy) : DW'(r1_dy);

    // Stage 3 combinational
    assign n3_den = QW'(r2_dxx) + QW'(r2_dzz);
    assign n3_num = QW'(r2_pxn) + QW'(r2_pzn);
    assign n3_d   = $signed(SW'(r2_d));

    always_comb begin
        n3_kill = r2_kill;
        if (r2_dy0) begin
            if (!r2_in) begin
                n3_kill = 1'b1;
            end
        end else if (r2_hin < 0 || r2_lon > n3_d) begin
            n3_kill = 1'b1;
        end

        if (r2_dy0) begin
            n3_m0 = scv_pkg::TSEL_ZERO;
            n3_m1 = scv_pkg::TSEL_ONE;
        end else begin
            if (r2_lon <= 0) begin
                n3_m0 = scv_pkg::TSEL_ZERO;
            end else if (r2_lon >= n3_d) begin
                n3_m0 = scv_pkg::TSEL_ONE;
            end else begin
                n3_m0 = scv_pkg::TSEL_DIV;
            end
            if (r2_hin <= 0) begin
                n3_m1 = scv_pkg::TSEL_ZERO;
            end else if (r2_hin >= n3_d) begin
                n3_m1 = scv_pkg::TSEL_ONE;
            end else begin
                n3_m1 = scv_pkg::TSEL_DIV;
            end
        end

        if (n3_den == '0) begin
            n3_mn = scv_pkg::TSEL_T0;
        end else if (n3_num <= 0) begin
            n3_mn = scv_pkg::TSEL_ZERO;
        end else if (n3_num >= n3_den) begin
            n3_mn = scv_pkg::TSEL_ONE;
        end else begin
            n3_mn = scv_pkg::TSEL_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r_vdl  <= '0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
            r8_vld <= 1'b0;
            r9_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld <= i_in_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r_vdl  <= {r_vdl[DL-2:0], r3_vld};
            r4_vld <= r_vdl[DL-1];
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
            r8_vld <= r7_vld;
            r9_vld <= r8_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_dx   <= DW'(i_seg_bx) - DW'(i_seg_ax);
            r1_dy   <= DW'(i_seg_by) - DW'(i_seg_ay);
            r1_dz   <= DW'(i_seg_bz) - DW'(i_seg_az);
            r1_cxa  <= DW'(i_cyl_x) - DW'(i_seg_ax);
            r1_cza  <= DW'(i_cyl_z) - DW'(i_seg_az);
            r1_low  <= SW'(i_cyl_y) + SW'(i_cyl_base_offset);
            r1_kill <= (i_cyl_radius == '0) || (i_cyl_height == '0);
            r1_ax   <= i_seg_ax;
            r1_ay   <= i_seg_ay;
            r1_az   <= i_seg_az;
            r1_cx   <= i_cyl_x;
            r1_cz   <= i_cyl_z;
            r1_h    <= i_cyl_height;
            r1_r    <= i_cyl_radius;

            r2_kill <= r1_kill;
            r2_dy0  <= (r1_dy == '0);
            r2_in   <= (n2_ay >= r1_low) && (n2_ay <= n2_high);
            r2_lon  <= n2_lon;
            r2_hin  <= n2_hin;
            r2_d    <= n2_d;
            r2_dxx  <= r1_dx * r1_dx;
            r2_dzz  <= r1_dz * r1_dz;
            r2_pxn  <= r1_cxa * r1_dx;
            r2_pzn  <= r1_cza * r1_dz;
            r2_dx   <= r1_dx;
            r2_dy   <= r1_dy;
            r2_dz   <= r1_dz;
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_az   <= r1_az;
            r2_cx   <= r1_cx;
            r2_cz   <= r1_cz;
            r2_r    <= r1_r;

            r3_kill <= n3_kill;
            r3_m0   <= n3_m0;
            r3_m1   <= n3_m1;
            r3_mn   <= n3_mn;
            r3_n0   <= (n3_m0 == scv_pkg::TSEL_DIV) ? DW'(r2_lon) : '0;
            r3_n1   <= (n3_m1 == scv_pkg::TSEL_DIV) ? DW'(r2_hin) : '0;
            r3_d    <= (r2_d == '0) ? DW'(1) : r2_d;
            r3_nn   <= (n3_mn == scv_pkg::TSEL_DIV) ? NW'(n3_num) : '0;
            r3_dn   <= (n3_den == '0) ? NW'(1) : NW'(n3_den);
            r3_dx   <= r2_dx;
            r3_dy   <= r2_dy;
            r3_dz   <= r2_dz;
            r3_ax   <= r2_ax;
            r3_ay   <= r2_ay;
            r3_az   <= r2_az;
            r3_cx   <= r2_cx;
            r3_cz   <= r2_cz;
            r3_r    <= r2_r;
        end
    end

    scv_div #(.W(DW), .STEPS(TF)) u_div_t0 (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r3_n0),
        .i_den (r3_d),
        .o_quo (w_q0)
    );

    scv_div #(.W(DW), .STEPS(TF)) u_div_t1 (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r3_n1),
        .i_den (r3_d),
        .o_quo (w_q1)
    );

    scv_div #(.W(NW), .STEPS(TF)) u_div_tn (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r3_nn),
        .i_den (r3_dn),
        .o_quo (w_qn)
    );

    assign w_sb_in = {r3_kill, 2'(r3_m0), 2'(r3_m1), 2'(r3_mn), r3_dx, r3_dy, r3_dz,
                      r3_ax, r3_ay, r3_az, r3_cx, r3_cz, r3_r};

    scv_delay #(.W(SBW), .DEPTH(DL)) u_side (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_data (w_sb_in),
        .o_data (w_sb_out)
    );

    assign {w_kill, w_m0b, w_m1b, w_mnb, w_dx, w_dy, w_dz,
            w_ax, w_ay, w_az, w_cx, w_cz, w_r} = w_sb_out;

    always_comb begin
        case (scv_pkg::t_tsel'(w_m0b))
            scv_pkg::TSEL_ONE: n4_t0 = T_ONE;
            scv_pkg::TSEL_DIV: n4_t0 = w_q0;
            default:           n4_t0 = '0;
        endcase
        case (scv_pkg::t_tsel'(w_m1b))
            scv_pkg::TSEL_ONE: n4_t1 = T_ONE;
            scv_pkg::TSEL_DIV: n4_t1 = w_q1;
            default:           n4_t1 = '0;
        endcase
        case (scv_pkg::t_tsel'(w_mnb))
            scv_pkg::TSEL_ONE: n4_tn = T_ONE;
            scv_pkg::TSEL_DIV: n4_tn = w_qn;
            scv_pkg::TSEL_T0:  n4_tn = n4_t0;
            default:           n4_tn = '0;
        endcase
        n4_tc = (n4_tn < n4_t0) ? n4_t0 : n4_tn;
        n4_t  = (n4_tc > n4_t1) ? n4_t1 : n4_tc;
    end

    assign w5_t = $signed({1'b0, r4_t});

    assign n6_wx = r5_mx + MW'(T_ONE >> 1);
    assign n6_wy = r5_my + MW'(T_ONE >> 1);
    assign n6_wz = r5_mz + MW'(T_ONE >> 1);
    assign n6_sx = n6_wx >>> TF;
    assign n6_sy = n6_wy >>> TF;
    assign n6_sz = n6_wz >>> TF;

    assign n9_dist = (PW+1)'($unsigned(r8_exx)) + (PW+1)'($unsigned(r8_ezz));
    assign n9_hit  = !r8_kill && (n9_dist <= (PW+1)'(r8_rr));

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_kill <= w_kill;
            r4_t    <= n4_t;
            r4_dx   <= w_dx;
            r4_dy   <= w_dy;
            r4_dz   <= w_dz;
            r4_ax   <= w_ax;
            r4_ay   <= w_ay;
            r4_az   <= w_az;
            r4_cx   <= w_cx;
            r4_cz   <= w_cz;
            r4_r    <= w_r;

            r5_kill <= r4_kill;
            r5_mx   <= r4_dx * w5_t;
            r5_my   <= r4_dy * w5_t;
            r5_mz   <= r4_dz * w5_t;
            r5_ax   <= r4_ax;
            r5_ay   <= r4_ay;
            r5_az   <= r4_az;
            r5_cx   <= r4_cx;
            r5_cz   <= r4_cz;
            r5_r    <= r4_r;

            r6_kill <= r5_kill;
            r6_px   <= CB'(r5_ax + n6_sx[CB-1:0]);
            r6_py   <= CB'(r5_ay + n6_sy[CB-1:0]);
            r6_pz   <= CB'(r5_az + n6_sz[CB-1:0]);
            r6_cx   <= r5_cx;
            r6_cz   <= r5_cz;
            r6_r    <= r5_r;

            r7_kill <= r6_kill;
            r7_ex   <= DW'(r6_px) - DW'(r6_cx);
            r7_ez   <= DW'(r6_pz) - DW'(r6_cz);
            r7_px   <= r6_px;
            r7_py   <= r6_py;
            r7_pz   <= r6_pz;
            r7_r    <= r6_r;

            r8_kill <= r7_kill;
            r8_exx  <= r7_ex * r7_ex;
            r8_ezz  <= r7_ez * r7_ez;
            r8_rr   <= RW'(r7_r) * RW'(r7_r);
            r8_px   <= r7_px;
            r8_py   <= r7_py;
            r8_pz   <= r7_pz;

            r9_hit  <= n9_hit;
            r9_x    <= n9_hit ? r8_px : '0;
            r9_y    <= n9_hit ? r8_py : '0;
            r9_z    <= n9_hit ? r8_pz : '0;
        end
    end

    assign o_out_valid = r9_vld;
    assign o_hit       = r9_hit;
    assign o_contact_x = r9_x;
    assign o_contact_y = r9_y;
    assign o_contact_z = r9_z;

endmodule

FILE: rtl/scv_div.sv
`timescale 1ns / 1ps

module scv_div #(
    parameter int W     = 25,
    parameter int STEPS = 16
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [W-1:0]     i_num,
    input  logic [W-1:0]     i_den,
    output logic [STEPS:0]   o_quo
);

    logic [W-1:0]     r_rem [STEPS];
    logic [W-1:0]     r_den [STEPS];
    logic [STEPS-1:0] r_q   [STEPS];
    logic [STEPS:0]   r_quo;
    logic [W:0]       w_fin_sh;
    logic             w_fin_up;

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        logic [W-1:0]     w_rem_in;
        logic [W-1:0]     w_den_in;
        logic [STEPS-1:0] w_q_in;
        logic [W:0]       w_sh;
        logic             w_ge;
        logic [W-1:0]     n_rem;

        if (s == 0) begin : g_first
            assign w_rem_in = i_num;
            assign w_den_in = i_den;
            assign w_q_in   = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_den_in = r_den[s-1];
            assign w_q_in   = r_q[s-1];
        end

        assign w_sh  = {w_rem_in, 1'b0};
        assign w_ge  = w_sh >= {1'b0, w_den_in};
        assign n_rem = w_ge ? W'(w_sh - {1'b0, w_den_in}) : w_sh[W-1:0];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_den[s] <= w_den_in;
                r_q[s]   <= {w_q_in[STEPS-2:0], w_ge};
            end
        end
    end

    // Round to nearest, ties upward: bump when twice the remainder reaches the divisor.
    assign w_fin_sh = {r_rem[STEPS-1], 1'b0};
    assign w_fin_up = w_fin_sh >= {1'b0, r_den[STEPS-1]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo <= {1'b0, r_q[STEPS-1]} + (STEPS+1)'(w_fin_up);
        end
    end

    assign o_quo = r_quo;

endmodule

FILE: rtl/scv_delay.sv
`timescale 1ns / 1ps

module scv_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_data,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_data = r_tap[DEPTH-1];

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CB = scv_pkg::COORD_BITS;
    localparam int TB = scv_pkg::T_FRAC_BITS;
    localparam longint ONE = longint'(1) << TB;
    localparam int SETTLE_CYCLES = 40;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef logic signed [CB-1:0] t_coord;
    typedef logic [CB-2:0] t_ulen;

    typedef struct {
        t_coord ax, ay, az, bx, by, bz;
        t_coord cx, cy, cz, off;
        t_ulen  height, radius;
    } t_probe;

    typedef struct {
        logic   hit;
        t_coord px, py, pz;
    } t_contact;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_in_valid = 1'b0;
    logic   o_in_stall;
    t_coord i_seg_ax = '0, i_seg_ay = '0, i_seg_az = '0;
    t_coord i_seg_bx = '0, i_seg_by = '0, i_seg_bz = '0;
    t_coord i_cyl_x = '0, i_cyl_y = '0, i_cyl_z = '0, i_cyl_base_offset = '0;
    t_ulen  i_cyl_height = '0, i_cyl_radius = '0;
    logic   o_out_valid;
    logic   i_out_stall = 1'b0;
    logic   o_hit;
    t_coord o_contact_x, o_contact_y, o_contact_z;

    t_contact expected_contacts[$];
    int  n_sent = 0, n_checked = 0, n_hits = 0, n_errors = 0;
    int  idle_cycles = 0;
    bit  no_gaps = 1'b0;
    int  out_hold = 0;

    always #1 i_clk = ~i_clk;

    segment_cylinder_hit_test dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_seg_ax(i_seg_ax), .i_seg_ay(i_seg_ay), .i_seg_az(i_seg_az),
        .i_seg_bx(i_seg_bx), .i_seg_by(i_seg_by), .i_seg_bz(i_seg_bz),
        .i_cyl_x(i_cyl_x), .i_cyl_y(i_cyl_y), .i_cyl_z(i_cyl_z),
        .i_cyl_base_offset(i_cyl_base_offset),
        .i_cyl_height(i_cyl_height), .i_cyl_radius(i_cyl_radius),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_hit(o_hit), .o_contact_x(o_contact_x), .o_contact_y(o_contact_y),
        .o_contact_z(o_contact_z)
    );

    function automatic longint slab_param(input longint n, input longint d);
        if (n <= 0) return 0;
        if (n >= d) return ONE;
        return (n * ONE + d / 2) / d;
    endfunction

    function automatic longint round_scale(input longint v);
        return (v + (longint'(1) << (TB - 1))) >>> TB;
    endfunction

    function automatic t_contact hit_point(input t_probe p);
        longint ax, ay, az, dx, dy, dz, cx, cz, lo_y, hi_y, h, r, d, lo_n, hi_n;
        longint den, num, t0, t1, t, px, py, pz, ex, ez;
        logic [127:0] wide_num, quo, rem;
        t_contact c;
        c = '{hit: 1'b0, px: '0, py: '0, pz: '0};
        ax = longint'(p.ax); ay = longint'(p.ay); az = longint'(p.az);
        dx = longint'(p.bx) - ax; dy = longint'(p.by) - ay; dz = longint'(p.bz) - az;
        cx = longint'(p.cx); cz = longint'(p.cz);
        h = longint'(p.height); r = longint'(p.radius);
        lo_y = longint'(p.cy) + longint'(p.off);
        hi_y = lo_y + h;
        if (r == 0 || h == 0) return c;
        t0 = 0;
        t1 = ONE;
        if (dy == 0) begin
            if (ay < lo_y || ay > hi_y) return c;
        end else begin
            d = dy > 0 ? dy : -dy;
            lo_n = dy > 0 ? lo_y - ay : ay - hi_y;
            hi_n = dy > 0 ? hi_y - ay : ay - lo_y;
            if (hi_n < 0 || lo_n > d) return c;
            t0 = slab_param(lo_n, d);
            t1 = slab_param(hi_n, d);
        end
        den = dx * dx + dz * dz;
        if (den == 0) begin
            t = t0;
        end else begin
            num = (cx - ax) * dx + (cz - az) * dz;
            if (num <= 0) begin
                t = 0;
            end else if (num >= den) begin
                t = ONE;
            end else begin
                wide_num = 128'(num) << TB;
                quo = wide_num / 128'(den);
                rem = wide_num - quo * 128'(den);
                t = longint'(quo);
                if ((rem << 1) >= 128'(den)) t++;
            end
        end
        if (t < t0) t = t0;
        if (t > t1) t = t1;
        px = ax + round_scale(dx * t);
        py = ay + round_scale(dy * t);
        pz = az + round_scale(dz * t);
        ex = px - cx;
        ez = pz - cz;
        if (ex * ex + ez * ez > r * r) return c;
        c.hit = 1'b1;
        c.px = px[CB-1:0];
        c.py = py[CB-1:0];
        c.pz = pz[CB-1:0];
        return c;
    endfunction

    function automatic int gap_len();
        if (no_gaps) return 0;
        if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 2);
    endfunction

    task automatic send_probe(input t_probe p);
        int gap;
        gap = gap_len();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_seg_ax <= p.ax; i_seg_ay <= p.ay; i_seg_az <= p.az;
        i_seg_bx <= p.bx; i_seg_by <= p.by; i_seg_bz <= p.bz;
        i_cyl_x <= p.cx; i_cyl_y <= p.cy; i_cyl_z <= p.cz;
        i_cyl_base_offset <= p.off;
        i_cyl_height <= p.height; i_cyl_radius <= p.radius;
        do @(posedge i_clk); while (o_in_stall);
        expected_contacts.push_back(hit_point(p));
        n_sent++;
    endtask

    always @(negedge i_clk) begin
        if (out_hold > 0) begin
            i_out_stall <= 1'b1;
            out_hold <= out_hold - 1;
        end else begin
            i_out_stall <= 1'b0;
            out_hold <= gap_len();
        end
    end

    always @(posedge i_clk) begin
        t_contact e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_contacts.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result beat hit=%0b", o_hit);
            end else begin
                e = expected_contacts.pop_front();
                if (o_hit !== e.hit || o_contact_x !== e.px || o_contact_y !== e.py
                        || o_contact_z !== e.pz) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch on beat %0d: expected %0b %0d %0d %0d, got %0b %0d %0d %0d",
                                 n_checked, e.hit, e.px, e.py, e.pz,
                                 o_hit, o_contact_x, o_contact_y, o_contact_z);
                end
                if (e.hit) n_hits++;
            end
            n_checked++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_contacts.size());
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_coord near(input t_coord center, input int span);
        return center + t_coord'($urandom_range(0, 2 * span)) - t_coord'(span);
    endfunction

    function automatic t_probe full_random_probe();
        t_probe p;
        p.ax = t_coord'($urandom); p.ay = t_coord'($urandom); p.az = t_coord'($urandom);
        p.bx = t_coord'($urandom); p.by = t_coord'($urandom); p.bz = t_coord'($urandom);
        p.cx = t_coord'($urandom); p.cy = t_coord'($urandom); p.cz = t_coord'($urandom);
        p.off = t_coord'($urandom);
        p.height = t_ulen'($urandom); p.radius = t_ulen'($urandom);
        return p;
    endfunction

    function automatic t_probe aimed_probe();
        t_probe p;
        int span;
        span = ($urandom_range(0, 7) == 0) ? 1 << 20 : 1 << 12;
        p.cx = near('0, 1 << 16); p.cy = near('0, 1 << 16); p.cz = near('0, 1 << 16);
        p.off = near('0, span);
        p.radius = t_ulen'($urandom_range(1, span));
        p.height = t_ulen'($urandom_range(1, 2 * span));
        p.ax = near(p.cx, 2 * span); p.az = near(p.cz, 2 * span);
        p.ay = near(p.cy + p.off, 2 * span);
        p.bx = near(p.cx, 2 * span); p.bz = near(p.cz, 2 * span);
        p.by = near(p.cy + p.off, 2 * span);
        case ($urandom_range(0, 7))
            0: p.by = p.ay;
            1: begin p.bx = p.ax; p.bz = p.az; end
            2: p.radius = '0;
            3: p.height = '0;
            default: ;
        endcase
        return p;
    endfunction

    function automatic t_probe base_probe();
        t_probe p;
        p = '{ax: -1000, ay: -512, az: 0, bx: 1000, by: 512, bz: 0,
              cx: 0, cy: 0, cz: 0, off: -256, height: 512, radius: 256};
        return p;
    endfunction

    task automatic test_degenerate_sizes();
        t_probe p;
        p = base_probe();
        p.radius = '0;
        send_probe(p);
        p = base_probe();
        p.height = '0;
        send_probe(p);
        p = base_probe();
        send_probe(p);
    endtask

    task automatic test_horizontal();
        t_probe p;
        p = base_probe();
        p.ay = 100; p.by = 100;
        send_probe(p);
        p.ay = 256; p.by = 256;
        send_probe(p);
        p.ay = -256; p.by = -256;
        send_probe(p);
        p.ay = 257; p.by = 257;
        send_probe(p);
    endtask

    task automatic test_slab_miss();
        t_probe p;
        p = base_probe();
        p.ay = 300; p.by = 900;
        send_probe(p);
        p.ay = -900; p.by = -300;
        send_probe(p);
        p.ay = 900; p.by = 256;
        send_probe(p);
    endtask

    task automatic test_vertical();
        t_probe p;
        p = base_probe();
        p.ax = 10; p.bx = 10; p.az = -20; p.bz = -20;
        send_probe(p);
        p.ax = 300; p.bx = 300;
        send_probe(p);
        p.ay = 5000; p.by = -5000;
        send_probe(p);
    endtask

    task automatic test_extremes();
        t_probe p;
        p = '{ax: {1'b1, {(CB-1){1'b0}}}, ay: {1'b1, {(CB-1){1'b0}}},
              az: {1'b1, {(CB-1){1'b0}}}, bx: {1'b0, {(CB-1){1'b1}}},
              by: {1'b0, {(CB-1){1'b1}}}, bz: {1'b0, {(CB-1){1'b1}}},
              cx: '0, cy: {1'b1, {(CB-1){1'b0}}}, cz: '0,
              off: {1'b1, {(CB-1){1'b0}}}, height: '1, radius: '1};
        send_probe(p);
        p.cy = {1'b0, {(CB-1){1'b1}}};
        p.off = {1'b0, {(CB-1){1'b1}}};
        send_probe(p);
        p = '{ax: {1'b0, {(CB-1){1'b1}}}, ay: '0, az: {1'b1, {(CB-1){1'b0}}},
              bx: {1'b1, {(CB-1){1'b0}}}, by: '0, bz: {1'b0, {(CB-1){1'b1}}},
              cx: {1'b0, {(CB-1){1'b1}}}, cy: '0, cz: {1'b0, {(CB-1){1'b1}}},
              off: '0, height: 1, radius: 1};
        send_probe(p);
        p.radius = '1;
        send_probe(p);
        p = base_probe();
        p.ax = -2; p.bx = 2; p.ay = -1; p.by = 1; p.radius = 1; p.height = 1;
        send_probe(p);
    endtask

    task automatic test_random(input int count);
        t_probe p;
        for (int i = 0; i < count; i++) begin
            no_gaps = ((i / 60) % 4) == 3;
            p = ($urandom_range(0, 4) == 0) ? full_random_probe() : aimed_probe();
            send_probe(p);
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_degenerate_sizes();
        test_horizontal();
        test_slab_miss();
        test_vertical();
        test_extremes();
        test_random(480);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_contacts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Checked %0d of %0d segment tests, %0d of them hits, %0d mismatches.",
                 n_checked, n_sent, n_hits, n_errors);
        $display("Covered size, slab, horizontal, vertical and full-range cases.");
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/scv_pkg.sv
rtl/scv_div.sv
rtl/scv_delay.sv
rtl/segment_cylinder_hit_test.sv
verif/tb.sv
